// File: rtl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared constants for the RGB555 2x2 box-filter mipmap downsampler.
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam int PIX_W  = 16;                    // packed pixel port width
    localparam int CH_W   = 5;                     // one color channel
    localparam int SUM_W  = CH_W + 1;              // sum of two channels
    localparam int PAIR_W = 3 * SUM_W;             // line store word
    localparam int DIM_W  = 11;                    // configured dimension
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IDX_W  = $clog2(LINE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    // Second pipeline stage control.
    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// File: rtl/rmd_lane.sv
// ----------------------------------------------------------------------------
// rmd_lane
// One color channel cell: sums a horizontal pixel pair, holds that sum for
// one stage, and averages it with the pair sum from the row above.
// ----------------------------------------------------------------------------
module rmd_lane
    import rmd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_advance,
    input  logic [CH_W-1:0]  i_left,
    input  logic [CH_W-1:0]  i_pix,
    input  logic [SUM_W-1:0] i_up,
    output logic [SUM_W-1:0] o_pair,
    output logic [CH_W-1:0]  o_avg
);

    logic [SUM_W-1:0] r_pair;
    logic [SUM_W:0]   quad_sum;

    assign o_pair = {1'b0, i_left} + {1'b0, i_pix};

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_pair <= o_pair;
        end
    end

    assign quad_sum = {1'b0, i_up} + {1'b0, r_pair};
    assign o_avg    = quad_sum[SUM_W:2];

endmodule

// File: rtl/rmd_line_store.sv
// ----------------------------------------------------------------------------
// rmd_line_store
// Line store of pair sums from even source rows, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module rmd_line_store
    import rmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [PAIR_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [PAIR_W-1:0] o_rdata
);

    logic [PAIR_W-1:0] r_mem [LINE_DEPTH];
    logic [PAIR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rgb555_mipmap_downsample_unit.sv
// ----------------------------------------------------------------------------
// rgb555_mipmap_downsample_unit
// 2x2 box-filter mipmap downsampler for X1R5G5B5 pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock while o_in_stall is low, and emits one
// averaged half-size pixel per 2x2 block, in raster order, with o_out_last on
// the final pixel of a frame. Each result passes through the registered line
// store read and then the output register after the transfer of its
// bottom-right source pixel. Odd trailing columns or rows are consumed without
// output. Writing either dimension restarts the frame at the top left pixel.
// ----------------------------------------------------------------------------
module rgb555_mipmap_downsample_unit
    import rmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_in_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_out_pixel,
    output logic                  o_out_last
);

    logic [DIM_W-1:0]  r_src_width, r_src_height;
    logic [DIM_W-1:0]  width_use, height_use;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [3*CH_W-1:0] r_left;
    logic [3*CH_W-1:0] cur_pix;
    t_stage_ctl        r_s1, n_s1;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_last;
    logic              advance, accept;
    logic              pair_cycle, wr_en;
    logic [IDX_W-1:0]  idx;
    logic [DIM_W-1:0]  col_next;
    logic [PAIR_W-1:0] pair_word, up_word;
    logic [3*CH_W-1:0] avg_pix;
    logic              is_last;

    // Dimensions in use, saturated to the supported range.
    always_comb begin
        if (r_src_width < DIM_MIN) begin
            width_use = DIM_MIN;
        end else if (r_src_width > WIDTH_MAX) begin
            width_use = WIDTH_MAX;
        end else begin
            width_use = r_src_width;
        end
        if (r_src_height < DIM_MIN) begin
            height_use = DIM_MIN;
        end else if (r_src_height > HEIGHT_MAX) begin
            height_use = HEIGHT_MAX;
        end else begin
            height_use = r_src_height;
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;

    assign cur_pix    = i_in_pixel[3*CH_W-1:0];
    assign idx        = r_col[COL_W-1:1];
    assign pair_cycle = accept && r_col[0];
    assign wr_en      = pair_cycle && !r_row[0];

    assign is_last = (idx == IDX_W'(width_use[DIM_W-1:1] - DIM_W'(1)))
                  && (r_row[ROW_W-1:1] == (ROW_W-1)'(height_use[DIM_W-1:1]
                                                      - DIM_W'(1)));

    always_comb begin
        n_s1.valid = pair_cycle && r_row[0];
        n_s1.last  = is_last;
    end

    assign col_next = DIM_W'(r_col) + DIM_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_next >= width_use) begin
                n_col = '0;
                if (DIM_W'(r_row) + DIM_W'(1) >= height_use) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = col_next[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_RESET;
            r_src_height <= DIM_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_s1         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_SRC_WIDTH
                             || i_cfg_index == CFG_SRC_HEIGHT)) begin
                if (i_cfg_index == CFG_SRC_WIDTH) begin
                    r_src_width <= i_cfg_data;
                end else begin
                    r_src_height <= i_cfg_data;
                end
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept && !r_col[0]) begin
                r_left <= cur_pix;
            end
            if (advance) begin
                r_s1        <= n_s1;
                r_out_valid <= r_s1.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pixel <= {1'b0, avg_pix};
            r_out_last  <= r_s1.last;
        end
    end

    // Red, green and blue cells; the pair sums go to the line store as R:G:B.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        rmd_lane u_lane (
            .i_clk     (i_clk),
            .i_advance (advance),
            .i_left    (r_left[g*CH_W +: CH_W]),
            .i_pix     (cur_pix[g*CH_W +: CH_W]),
            .i_up      (up_word[g*SUM_W +: SUM_W]),
            .o_pair    (pair_word[g*SUM_W +: SUM_W]),
            .o_avg     (avg_pix[g*CH_W +: CH_W])
        );
    end

    rmd_line_store u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (idx),
        .i_wdata (pair_word),
        .i_re    (advance),
        .i_raddr (idx),
        .o_rdata (up_word)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_out_last  = r_out_last;

endmodule
